// ===== design/hmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Memory map decoder package
// Target codes, read source codes, map constants, the decode record and the
// boot program image shared by the decoder, the top level and the checker.
// ----------------------------------------------------------------------------
package hmmd_pkg;

    typedef enum logic [2:0] {
        TGT_INTERNAL = 3'd0,
        TGT_CART     = 3'd1,
        TGT_VRAM     = 3'd2,
        TGT_OAM      = 3'd3,
        TGT_VREGS    = 3'd4,
        TGT_JOYPAD   = 3'd5,
        TGT_TIMER    = 3'd6
    } t_target;

    typedef enum logic [2:0] {
        RS_ZERO = 3'd0,
        RS_BOOT = 3'd1,
        RS_EXT  = 3'd2,
        RS_WORK = 3'd3,
        RS_ZP   = 3'd4,
        RS_IE   = 3'd5,
        RS_IF   = 3'd6
    } t_rsrc;

    localparam logic        FUNC_READ     = 1'b0;
    localparam logic        FUNC_WRITE    = 1'b1;
    localparam logic [15:0] WORK_END      = 16'hFE00;
    localparam logic [15:0] OAM_END       = 16'hFEA0;
    localparam logic [15:0] VREGS_BASE    = 16'hFF40;
    localparam logic [15:0] ZP_BASE       = 16'hFF80;
    localparam logic [15:0] JOYPAD_ADDR   = 16'hFF00;
    localparam logic [13:0] TIMER_BLOCK   = 14'h3FC1;
    localparam logic [15:0] IF_ADDR       = 16'hFF0F;
    localparam logic [15:0] IE_ADDR       = 16'hFFFF;
    localparam logic [15:0] BOOT_EXIT_PC  = 16'h0100;
    localparam logic [14:0] VRAM_OFS_MASK = 15'h1FFF;

    typedef struct packed {
        t_target     tgt;
        logic [14:0] off;
        logic        fwd_wr;
        t_rsrc       src;
        logic        we_ext;
        logic        we_work;
        logic        we_zp;
        logic        we_ie;
        logic        we_if;
        logic        leave_boot;
    } t_decode;

    localparam logic [7:0] BOOT_IMAGE [256] = '{
        8'h31, 8'hFE, 8'hFF, 8'hAF, 8'h21, 8'hFF, 8'h9F, 8'h32,
        8'hCB, 8'h7C, 8'h20, 8'hFB, 8'h21, 8'h26, 8'hFF, 8'h0E,
        8'h11, 8'h3E, 8'h80, 8'h32, 8'hE2, 8'h0C, 8'h3E, 8'hF3,
        8'hE2, 8'h32, 8'h3E, 8'h77, 8'h77, 8'h3E, 8'hFC, 8'hE0,
        8'h47, 8'h11, 8'h04, 8'h01, 8'h21, 8'h10, 8'h80, 8'h1A,
        8'hCD, 8'h95, 8'h00, 8'hCD, 8'h96, 8'h00, 8'h13, 8'h7B,
        8'hFE, 8'h34, 8'h20, 8'hF3, 8'h11, 8'hD8, 8'h00, 8'h06,
        8'h08, 8'h1A, 8'h13, 8'h22, 8'h23, 8'h05, 8'h20, 8'hF9,
        8'h3E, 8'h19, 8'hEA, 8'h10, 8'h99, 8'h21, 8'h2F, 8'h99,
        8'h0E, 8'h0C, 8'h3D, 8'h28, 8'h08, 8'h32, 8'h0D, 8'h20,
        8'hF9, 8'h2E, 8'h0F, 8'h18, 8'hF3, 8'h67, 8'h3E, 8'h64,
        8'h57, 8'hE0, 8'h42, 8'h3E, 8'h91, 8'hE0, 8'h40, 8'h04,
        8'h1E, 8'h02, 8'h0E, 8'h0C, 8'hF0, 8'h44, 8'hFE, 8'h90,
        8'h20, 8'hFA, 8'h0D, 8'h20, 8'hF7, 8'h1D, 8'h20, 8'hF2,
        8'h0E, 8'h13, 8'h24, 8'h7C, 8'h1E, 8'h83, 8'hFE, 8'h62,
        8'h28, 8'h06, 8'h1E, 8'hC1, 8'hFE, 8'h64, 8'h20, 8'h06,
        8'h7B, 8'hE2, 8'h0C, 8'h3E, 8'h87, 8'hF2, 8'hF0, 8'h42,
        8'h90, 8'hE0, 8'h42, 8'h15, 8'h20, 8'hD2, 8'h05, 8'h20,
        8'h4F, 8'h16, 8'h20, 8'h18, 8'hCB, 8'h4F, 8'h06, 8'h04,
        8'hC5, 8'hCB, 8'h11, 8'h17, 8'hC1, 8'hCB, 8'h11, 8'h17,
        8'h05, 8'h20, 8'hF5, 8'h22, 8'h23, 8'h22, 8'h23, 8'hC9,
        8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
        8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
        8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
        8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
        8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E,
        8'h3C, 8'h42, 8'hB9, 8'hA5, 8'hB9, 8'hA5, 8'h42, 8'h4C,
        8'h21, 8'h04, 8'h01, 8'h11, 8'hA8, 8'h00, 8'h1A, 8'h13,
        8'hBE, 8'h20, 8'hFE, 8'h23, 8'h7D, 8'hFE, 8'h34, 8'h20,
        8'hF5, 8'h06, 8'h19, 8'h78, 8'h86, 8'h23, 8'h05, 8'h20,
        8'hFB, 8'h86, 8'h20, 8'hFE, 8'h3E, 8'h01, 8'hE0, 8'h50
    };

endpackage

// ===== design/hmmd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read per cycle at the same address, with the read data registered.
// ----------------------------------------------------------------------------
module hmmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/hmmd_decode.sv =====
// ----------------------------------------------------------------------------
// Memory map address decoder
// Classifies one bus access against the memory map and yields the target,
// offset, internal read source and the write enables of the internal stores.
// ----------------------------------------------------------------------------
module hmmd_decode (
    input  logic             i_func,
    input  logic [15:0]      i_addr,
    input  logic [15:0]      i_cpu_pc,
    input  logic             i_overlay_on,
    output hmmd_pkg::t_decode o_dec
);
    import hmmd_pkg::*;

    t_target     tgt;
    logic [14:0] off;
    t_rsrc       src;
    logic        we_ext;
    logic        we_work;
    logic        we_zp;
    logic        we_ie;
    logic        we_if;
    logic        leave_boot;
    logic        wr;

    assign wr = (i_func == FUNC_WRITE);

    always_comb begin
        tgt        = TGT_INTERNAL;
        off        = '0;
        src        = RS_ZERO;
        we_ext     = 1'b0;
        we_work    = 1'b0;
        we_zp      = 1'b0;
        we_ie      = 1'b0;
        we_if      = 1'b0;
        leave_boot = 1'b0;
        if (!i_addr[15]) begin
            if (!wr) begin
                if (i_overlay_on && (i_addr[15:8] == 8'h00)) begin
                    src = RS_BOOT;
                end else begin
                    tgt        = TGT_CART;
                    off        = i_addr[14:0];
                    leave_boot = i_overlay_on && (i_addr[15:12] == 4'h0)
                                 && (i_cpu_pc == BOOT_EXIT_PC);
                end
            end
        end else if (i_addr[15:13] == 3'b100) begin
            tgt = TGT_VRAM;
            off = i_addr[14:0] & VRAM_OFS_MASK;
        end else if (i_addr[15:13] == 3'b101) begin
            we_ext = wr;
            src    = wr ? RS_ZERO : RS_EXT;
        end else if (i_addr < WORK_END) begin
            we_work = wr;
            src     = wr ? RS_ZERO : RS_WORK;
        end else if (i_addr[15:8] == 8'hFE) begin
            if (i_addr < OAM_END) begin
                tgt = TGT_OAM;
                off = {7'd0, i_addr[7:0]};
            end
        end else if (i_addr >= ZP_BASE) begin
            we_zp = wr;
            if (i_addr == IE_ADDR) begin
                we_ie = wr;
                src   = wr ? RS_ZERO : RS_IE;
            end else begin
                src   = wr ? RS_ZERO : RS_ZP;
            end
        end else if (i_addr >= VREGS_BASE) begin
            tgt = TGT_VREGS;
            off = {7'd0, i_addr[7:0]};
        end else if (i_addr == JOYPAD_ADDR) begin
            tgt = TGT_JOYPAD;
            off = {7'd0, i_addr[7:0]};
        end else if (i_addr[15:2] == TIMER_BLOCK) begin
            tgt = TGT_TIMER;
            off = {7'd0, i_addr[7:0]};
        end else if (i_addr == IF_ADDR) begin
            we_if = wr;
            src   = wr ? RS_ZERO : RS_IF;
        end
    end

    always_comb begin
        o_dec.tgt        = tgt;
        o_dec.off        = off;
        o_dec.fwd_wr     = wr && (tgt != TGT_INTERNAL);
        o_dec.src        = src;
        o_dec.we_ext     = we_ext;
        o_dec.we_work    = we_work;
        o_dec.we_zp      = we_zp;
        o_dec.we_ie      = we_ie;
        o_dec.we_if      = we_if;
        o_dec.leave_boot = leave_boot;
    end

endmodule

// ===== design/handheld_memory_map_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Handheld memory map decoder unit
// Decodes byte bus accesses, serves the internal RAMs, interrupt bytes and
// boot ROM overlay, and forwards other accesses as a target code and offset.
//
// Channel  Direction  Handshake                  Payload
// access   in         start && !busy             i_func, i_addr, i_wdata,
//                                                i_cpu_pc
// result   out        o_valid, one-cycle strobe  o_target, o_target_offset,
//                                                o_target_write, o_target_wdata,
//                                                o_rdata
//
// One access can be taken in every cycle while busy is low; its result passes
// through the stage-one registers and then the output registers, the first
// stage matching the registered read of the RAMs. After reset busy stays high
// while the work, external and zero-page RAMs are cleared one entry a cycle.
// The receiver cannot stall, so nothing else holds off a transfer.
// ----------------------------------------------------------------------------
module handheld_memory_map_decoder_unit #(
    parameter int WORK_RAM_BYTES  = 8192,
    parameter int EXT_RAM_BYTES   = 8192,
    parameter int ZERO_PAGE_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    input  logic [15:0] i_cpu_pc,
    output logic        o_valid,
    output logic [2:0]  o_target,
    output logic [14:0] o_target_offset,
    output logic        o_target_write,
    output logic [7:0]  o_target_wdata,
    output logic [7:0]  o_rdata
);
    import hmmd_pkg::*;

    localparam int WR_AW   = $clog2(WORK_RAM_BYTES);
    localparam int EXT_AW  = $clog2(EXT_RAM_BYTES);
    localparam int ZP_AW   = $clog2(ZERO_PAGE_BYTES);
    localparam int CLR_MAX = (WORK_RAM_BYTES > EXT_RAM_BYTES) ? WORK_RAM_BYTES : EXT_RAM_BYTES;
    localparam int CLR_DEPTH = (CLR_MAX > ZERO_PAGE_BYTES) ? CLR_MAX : ZERO_PAGE_BYTES;
    localparam int CLR_AW  = $clog2(CLR_DEPTH);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CLR_AW-1:0]  r_clr;
    logic [CLR_AW-1:0]  n_clr;
    logic               clearing;
    logic               accept;
    t_decode            dec;

    logic               r_overlay_on;
    logic [7:0]         r_ie;
    logic [7:0]         r_if;

    logic               r_s1_valid;
    t_target            r_s1_tgt;
    logic [14:0]        r_s1_off;
    logic               r_s1_fwd_wr;
    logic [7:0]         r_s1_wdata;
    t_rsrc              r_s1_src;
    logic [7:0]         r_s1_boot_idx;
    logic [7:0]         r_s1_reg;

    logic               r_valid;
    t_target            r_target;
    logic [14:0]        r_offset;
    logic               r_twrite;
    logic [7:0]         r_twdata;
    logic [7:0]         r_rdata;
    logic [7:0]         n_rdata;

    logic               ext_we;
    logic [EXT_AW-1:0]  ext_addr;
    logic [7:0]         ext_wdata;
    logic [7:0]         ext_q;
    logic               work_we;
    logic [WR_AW-1:0]   work_addr;
    logic [7:0]         work_wdata;
    logic [7:0]         work_q;
    logic               zp_we;
    logic [ZP_AW-1:0]   zp_addr;
    logic [7:0]         zp_wdata;
    logic [7:0]         zp_q;

    assign clearing = (r_state == ST_CLEAR);
    assign busy     = clearing;
    assign accept   = start && !busy;

    hmmd_decode u_decode (
        .i_func       (i_func),
        .i_addr       (i_addr),
        .i_cpu_pc     (i_cpu_pc),
        .i_overlay_on (r_overlay_on),
        .o_dec        (dec)
    );

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == CLR_AW'(CLR_DEPTH - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_clr = '0;
            end
            default: begin
                n_state = ST_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_overlay_on <= 1'b1;
            r_ie         <= '0;
            r_if         <= '0;
            r_s1_valid   <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_s1_valid <= accept;
            r_valid    <= r_s1_valid;
            if (accept && dec.leave_boot) begin
                r_overlay_on <= 1'b0;
            end
            if (accept && dec.we_ie) begin
                r_ie <= i_wdata;
            end
            if (accept && dec.we_if) begin
                r_if <= i_wdata;
            end
        end
    end

    assign ext_we     = clearing || (accept && dec.we_ext);
    assign ext_addr   = clearing ? r_clr[EXT_AW-1:0] : i_addr[EXT_AW-1:0];
    assign ext_wdata  = clearing ? 8'd0 : i_wdata;
    assign work_we    = clearing || (accept && dec.we_work);
    assign work_addr  = clearing ? r_clr[WR_AW-1:0] : i_addr[WR_AW-1:0];
    assign work_wdata = clearing ? 8'd0 : i_wdata;
    assign zp_we      = clearing || (accept && dec.we_zp);
    assign zp_addr    = clearing ? r_clr[ZP_AW-1:0] : i_addr[ZP_AW-1:0];
    assign zp_wdata   = clearing ? 8'd0 : i_wdata;

    hmmd_ram #(.WIDTH(8), .DEPTH(EXT_RAM_BYTES)) u_ext_ram (
        .i_clk   (i_clk),
        .i_we    (ext_we),
        .i_addr  (ext_addr),
        .i_wdata (ext_wdata),
        .o_rdata (ext_q)
    );

    hmmd_ram #(.WIDTH(8), .DEPTH(WORK_RAM_BYTES)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (work_we),
        .i_addr  (work_addr),
        .i_wdata (work_wdata),
        .o_rdata (work_q)
    );

    hmmd_ram #(.WIDTH(8), .DEPTH(ZERO_PAGE_BYTES)) u_zp_ram (
        .i_clk   (i_clk),
        .i_we    (zp_we),
        .i_addr  (zp_addr),
        .i_wdata (zp_wdata),
        .o_rdata (zp_q)
    );

    always_ff @(posedge i_clk) begin
        r_s1_tgt      <= dec.tgt;
        r_s1_off      <= dec.off;
        r_s1_fwd_wr   <= dec.fwd_wr;
        r_s1_wdata    <= dec.fwd_wr ? i_wdata : 8'd0;
        r_s1_src      <= dec.src;
        r_s1_boot_idx <= i_addr[7:0];
        r_s1_reg      <= (dec.src == RS_IE) ? r_ie : r_if;
    end

    always_comb begin
        case (r_s1_src)
            RS_BOOT: n_rdata = BOOT_IMAGE[r_s1_boot_idx];
            RS_EXT:  n_rdata = ext_q;
            RS_WORK: n_rdata = work_q;
            RS_ZP:   n_rdata = zp_q;
            RS_IE:   n_rdata = r_s1_reg;
            RS_IF:   n_rdata = r_s1_reg;
            default: n_rdata = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_target <= r_s1_tgt;
        r_offset <= r_s1_off;
        r_twrite <= r_s1_fwd_wr;
        r_twdata <= r_s1_wdata;
        r_rdata  <= n_rdata;
    end

    assign o_valid         = r_valid;
    assign o_target        = r_target;
    assign o_target_offset = r_offset;
    assign o_target_write  = r_twrite;
    assign o_target_wdata  = r_twdata;
    assign o_rdata         = r_rdata;

endmodule

// ===== design/hmmd_checker.sv =====
// ----------------------------------------------------------------------------
// Memory map decoder port checker
// Watches the ports of the top level for consistency of results over time.
// ----------------------------------------------------------------------------
module hmmd_port_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [2:0]  o_target,
    input logic        o_target_write,
    input logic [7:0]  o_target_wdata,
    input logic [7:0]  o_rdata
);
    import hmmd_pkg::*;

    a_result_follows_transfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, 2)
    ) else $error("result strobe without a transfer two cycles earlier");

    a_no_result_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid
    ) else $error("result strobe during the clearing pass");

    a_internal_not_forwarded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_target == TGT_INTERNAL)) |-> !o_target_write
    ) else $error("internal access marked as a forwarded write");

    a_forwarded_no_rdata: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_target != TGT_INTERNAL)) |-> (o_rdata == 8'd0)
    ) else $error("forwarded access carries read data");

    a_wdata_only_on_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_target_write) |-> (o_target_wdata == 8'd0)
    ) else $error("write data without a forwarded write");

endmodule

bind handheld_memory_map_decoder_unit hmmd_port_assertions u_hmmd_port_assertions (.*);

// ===== verif/hmmd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Memory map decoder checker
// Watches the access and result channels of the decoder. Each accepted access
// is decoded against its own copy of the memory map, RAM contents, interrupt
// bytes and boot overlay flag. The expected result is queued and then compared,
// field by field, with the next result strobe.
// ----------------------------------------------------------------------------
module hmmd_checker
    import hmmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_func,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    input  logic [15:0] i_cpu_pc,
    input  logic        i_valid,
    input  logic [2:0]  i_target,
    input  logic [14:0] i_target_offset,
    input  logic        i_target_write,
    input  logic [7:0]  i_target_wdata,
    input  logic [7:0]  i_rdata,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        t_target     tgt;
        logic [14:0] off;
        logic        wr;
        logic [7:0]  wdata;
        logic [7:0]  rdata;
    } t_access_result;

    logic           boot_mapped;
    logic [7:0]     ext_mem [8192];
    logic [7:0]     work_mem [8192];
    logic [7:0]     zp_mem [128];
    logic [7:0]     int_enable;
    logic [7:0]     int_flags;
    t_access_result expected_results [$];
    int             reports;

    function automatic t_access_result decode_access(input logic wr, input logic [15:0] a,
                                                     input logic [7:0] wd,
                                                     input logic [15:0] pc);
        t_access_result r;
        logic [7:0]     rd;
        r  = '{TGT_INTERNAL, 15'd0, 1'b0, 8'd0, 8'd0};
        rd = 8'd0;
        if (a < 16'h8000) begin
            if (!wr) begin
                if (boot_mapped && a < BOOT_EXIT_PC) begin
                    rd = BOOT_IMAGE[a[7:0]];
                end else begin
                    if (a < 16'h1000 && boot_mapped && pc == BOOT_EXIT_PC)
                        boot_mapped = 1'b0;
                    r.tgt = TGT_CART;
                    r.off = a[14:0];
                end
            end
        end else if (a < 16'hA000) begin
            r.tgt = TGT_VRAM;
            r.off = {2'b00, a[12:0]};
        end else if (a < 16'hC000) begin
            if (wr) ext_mem[a[12:0]] = wd;
            else rd = ext_mem[a[12:0]];
        end else if (a < WORK_END) begin
            if (wr) work_mem[a[12:0]] = wd;
            else rd = work_mem[a[12:0]];
        end else if (a < JOYPAD_ADDR) begin
            if (a < OAM_END) begin
                r.tgt = TGT_OAM;
                r.off = {7'd0, a[7:0]};
            end
        end else if (a >= ZP_BASE) begin
            if (wr) begin
                if (a == IE_ADDR) int_enable = wd;
                zp_mem[a[6:0]] = wd;
            end else begin
                rd = (a == IE_ADDR) ? int_enable : zp_mem[a[6:0]];
            end
        end else if (a >= VREGS_BASE) begin
            r.tgt = TGT_VREGS;
            r.off = {7'd0, a[7:0]};
        end else if (a == JOYPAD_ADDR) begin
            r.tgt = TGT_JOYPAD;
            r.off = {7'd0, a[7:0]};
        end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
            r.tgt = TGT_TIMER;
            r.off = {7'd0, a[7:0]};
        end else if (a == IF_ADDR) begin
            if (wr) int_flags = wd;
            else rd = int_flags;
        end
        r.wr    = (r.tgt != TGT_INTERNAL) && wr;
        r.wdata = r.wr ? wd : 8'd0;
        r.rdata = (r.tgt == TGT_INTERNAL && !wr) ? rd : 8'd0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_access_result got;
        t_access_result exp_res;
        if (!i_rst_n) begin
            boot_mapped = 1'b1;
            for (int i = 0; i < 8192; i++) begin
                ext_mem[i]  = 8'd0;
                work_mem[i] = 8'd0;
            end
            for (int i = 0; i < 128; i++)
                zp_mem[i] = 8'd0;
            int_enable = 8'd0;
            int_flags  = 8'd0;
            expected_results.delete();
            o_pending = 0;
            o_errors  = 0;
            reports   = 0;
        end else begin
            if (i_valid === 1'b1) begin
                got = '{t_target'(i_target), i_target_offset, i_target_write,
                        i_target_wdata, i_rdata};
                if (expected_results.size() == 0) begin
                    if (reports < 10)
                        $display({"Result with no access outstanding: ",
                                  "tgt=%0d off=%h wr=%b wd=%h rd=%h"},
                                 got.tgt, got.off, got.wr, got.wdata, got.rdata);
                    reports++;
                    o_errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got !== exp_res) begin
                        if (reports < 10)
                            $display({"Mismatch: exp tgt=%0d off=%h wr=%b wd=%h rd=%h, ",
                                      "got tgt=%0d off=%h wr=%b wd=%h rd=%h"},
                                     exp_res.tgt, exp_res.off, exp_res.wr, exp_res.wdata,
                                     exp_res.rdata, got.tgt, got.off, got.wr, got.wdata,
                                     got.rdata);
                        reports++;
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(decode_access(i_func == FUNC_WRITE, i_addr,
                                                         i_wdata, i_cpu_pc));
            o_pending = expected_results.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Memory map decoder testbench
// Drives directed accesses at every region edge and special case, then about
// a thousand random accesses biased towards RAM read-back and the boot overlay
// exit, with random idle cycles. The checker compares every result transfer.
// ----------------------------------------------------------------------------
module tb;
    import hmmd_pkg::*;

    localparam int ITEMS = 1100;
    localparam int LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        func = 1'b0;
    logic [15:0] addr = 16'd0;
    logic [7:0]  wdata = 8'd0;
    logic [15:0] cpu_pc = 16'd0;
    logic        valid;
    logic [2:0]  target;
    logic [14:0] target_offset;
    logic        target_write;
    logic [7:0]  target_wdata;
    logic [7:0]  rdata;
    int          errors;
    int          pending;
    int          cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    handheld_memory_map_decoder_unit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (func),
        .i_addr         (addr),
        .i_wdata        (wdata),
        .i_cpu_pc       (cpu_pc),
        .o_valid        (valid),
        .o_target       (target),
        .o_target_offset(target_offset),
        .o_target_write (target_write),
        .o_target_wdata (target_wdata),
        .o_rdata        (rdata)
    );

    hmmd_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_func         (func),
        .i_addr         (addr),
        .i_wdata        (wdata),
        .i_cpu_pc       (cpu_pc),
        .i_valid        (valid),
        .i_target       (target),
        .i_target_offset(target_offset),
        .i_target_write (target_write),
        .i_target_wdata (target_wdata),
        .i_rdata        (rdata),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic bus_idle(input int idx);
        if (!(idx >= 500 && idx < 700) && $urandom_range(0, 99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic bus_access(input logic f, input logic [15:0] a, input logic [7:0] d,
                              input logic [15:0] pc);
        start  <= 1'b1;
        func   <= f;
        addr   <= a;
        wdata  <= d;
        cpu_pc <= pc;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic random_access(input int idx);
        logic        f;
        logic [15:0] a;
        logic [15:0] pc;
        logic [15:0] ofs;
        logic [7:0]  d;
        f   = 1'($urandom_range(0, 1));
        d   = 8'($urandom);
        pc  = 16'($urandom);
        ofs = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'h1FFF))
                                          : 16'($urandom_range(0, 63));
        case ($urandom_range(0, 15))
            0: a = 16'($urandom_range(0, 16'h00FF));
            1: begin
                a = 16'($urandom_range(16'h0100, 16'h0FFF));
                if ($urandom_range(0, 3) == 0) pc = BOOT_EXIT_PC;
            end
            2: a = 16'($urandom_range(16'h1000, 16'h7FFF));
            3: a = 16'($urandom_range(16'h8000, 16'h9FFF));
            4, 5: a = 16'hA000 + ofs;
            6, 7: a = ($urandom_range(0, 1) ? 16'hC000 : 16'hE000) + ofs;
            8: a = 16'($urandom_range(16'hFE00, 16'hFEFF));
            9, 10: a = 16'($urandom_range(16'hFF00, 16'hFF7F));
            11, 12: a = 16'($urandom_range(16'hFF80, 16'hFFFF));
            13: a = IF_ADDR;
            default: a = 16'($urandom);
        endcase
        // Keep the boot overlay mapped for the first part of the run.
        if (idx < 300 && pc == BOOT_EXIT_PC) pc[0] = 1'b1;
        bus_access(f, a, d, pc);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        bus_access(FUNC_READ, 16'h0000, 8'h00, 16'h0000);
        bus_access(FUNC_READ, 16'h00FF, 8'hFF, BOOT_EXIT_PC);
        bus_access(FUNC_WRITE, 16'h0000, 8'hFF, 16'hFFFF);
        bus_access(FUNC_WRITE, 16'h0100, 8'h55, BOOT_EXIT_PC);
        bus_access(FUNC_READ, 16'h1000, 8'h00, BOOT_EXIT_PC);
        bus_access(FUNC_READ, 16'h7FFF, 8'hAA, 16'h0101);
        bus_access(FUNC_WRITE, 16'h8000, 8'hA5, 16'h0000);
        bus_access(FUNC_READ, 16'h9FFF, 8'h00, 16'h0000);
        bus_access(FUNC_WRITE, 16'hA000, 8'h5A, 16'h0000);
        bus_access(FUNC_READ, 16'hA000, 8'h00, 16'h0000);
        bus_access(FUNC_WRITE, 16'hBFFF, 8'hFF, 16'h0000);
        bus_access(FUNC_READ, 16'hBFFF, 8'h00, 16'h0000);
        bus_access(FUNC_WRITE, 16'hC000, 8'h3C, 16'h0000);
        bus_access(FUNC_READ, 16'hE000, 8'h00, 16'h0000);
        bus_access(FUNC_WRITE, 16'hFDFF, 8'h81, 16'h0000);
        bus_access(FUNC_READ, 16'hDDFF, 8'h00, 16'h0000);
        bus_access(FUNC_WRITE, 16'hFE9F, 8'h7E, 16'h0000);
        bus_access(FUNC_WRITE, 16'hFEA0, 8'hC3, 16'h0000);
        bus_access(FUNC_READ, 16'hFEFF, 8'h00, 16'h0000);
        bus_access(FUNC_READ, JOYPAD_ADDR, 8'h00, 16'h0000);
        bus_access(FUNC_WRITE, 16'hFF07, 8'h05, 16'h0000);
        bus_access(FUNC_READ, 16'hFF01, 8'h00, 16'h0000);
        bus_access(FUNC_WRITE, IF_ADDR, 8'hE7, 16'h0000);
        bus_access(FUNC_READ, IF_ADDR, 8'h00, 16'h0000);
        bus_access(FUNC_WRITE, IE_ADDR, 8'h1F, 16'h0000);
        bus_access(FUNC_READ, IE_ADDR, 8'h00, 16'h0000);
        bus_access(FUNC_WRITE, 16'hFF7F, 8'h91, 16'h0000);

        for (int i = 0; i < ITEMS; i++) begin
            bus_idle(i);
            random_access(i);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
design/hmmd_pkg.sv
design/hmmd_ram.sv
design/hmmd_decode.sv
design/handheld_memory_map_decoder_unit.sv
design/hmmd_checker.sv
verif/hmmd_checker.sv
verif/tb.sv
